// ----- rtl/core/arithmetic_coder_encoder_assert.svh -----
// Assertion macros shared by the divider and datapath modules of the arithmetic coder encoder.
`ifndef ARITHMETIC_CODER_ENCODER_ASSERT_SVH
`define ARITHMETIC_CODER_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ACE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ace_pkg.sv -----
// Package with constants and types of the arithmetic coder encoder.
package ace_pkg;

  localparam int RANGE_BITS_DEF = 32;
  localparam int CNT_W          = 16;
  localparam int FOLLOW_W       = 6;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [FOLLOW_W-1:0] PENDING_MAX = 6'd62;
  localparam logic [CNT_W-1:0]    TOTAL_RESET = 16'd1;
  localparam logic [0:0]          REG_TOTAL_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_RENORM,
    ST_SHRINK,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul_hi;
    logic mul_lo;
    logic div_start;
    logic update;
    logic emit;
    logic shrink;
    logic finish;
  } ace_cmd_t;

  typedef struct packed {
    logic in_finish;
    logic in_empty;
    logic div_busy;
    logic emit_cond;
    logic shrink_cond;
    logic out_free;
  } ace_status_t;

endpackage

// ----- rtl/core/ace_div.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle.
`include "arithmetic_coder_encoder_assert.svh"

module ace_div #(
  parameter int QW = ace_pkg::RANGE_BITS_DEF + 1,
  parameter int DW = ace_pkg::CNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] dividend_a,
  input  logic [QW+DW-1:0] dividend_b,
  input  logic [DW-1:0]    divisor,
  output logic             busy,
  output logic [QW-1:0]    quot_a,
  output logic [QW-1:0]    quot_b
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0]    dvsr;
  logic [CW-1:0]    count;
  logic [DW-1:0]    rem [2];
  logic [QW-1:0]    quo [2];
  logic [DW-1:0]    rem_next [2];
  logic [QW-1:0]    quo_next [2];
  logic [QW+DW-1:0] dividend [2];

  assign dividend[0] = dividend_a;
  assign dividend[1] = dividend_b;

  always_comb begin
    logic [DW+1:0] diff;
    logic          ge;
    for (int i = 0; i < 2; i++) begin
      diff = {1'b0, rem[i], quo[i][QW-1]} - {2'b00, dvsr};
      ge   = !diff[DW+1];
      rem_next[i] = ge ? diff[DW-1:0] : {rem[i][DW-2:0], quo[i][QW-1]};
      quo_next[i] = {quo[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(QW);
    end else if (busy) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      for (int i = 0; i < 2; i++) begin
        rem[i] <= dividend[i][QW+DW-1:QW];
        quo[i] <= dividend[i][QW-1:0];
      end
    end else if (busy) begin
      for (int i = 0; i < 2; i++) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
      end
    end
  end

  assign busy   = (count != '0);
  assign quot_a = quo[0];
  assign quot_b = quo[1];

  `ACE_ASSERT_IMPL(a_start_idle, clk, rst, start, !busy)

endmodule

// ----- rtl/core/ace_datapath.sv -----
// Datapath of the arithmetic coder encoder: interval state, scaling and output register.
`include "arithmetic_coder_encoder_assert.svh"

module ace_datapath #(
  parameter int RANGE_BITS = ace_pkg::RANGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ace_pkg::ace_cmd_t               cmd,
  output ace_pkg::ace_status_t            status,
  input  logic [ace_pkg::CNT_W-1:0]       total_count,
  input  logic [0:0]                      s_tuser,
  input  logic [ace_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ace_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);

  localparam int SW = RANGE_BITS + 1;
  localparam int CW = ace_pkg::CNT_W;
  localparam int PW = SW + CW;
  localparam int FW = ace_pkg::FOLLOW_W;

  localparam logic [SW-1:0] WHOLE   = SW'(1) << RANGE_BITS;
  localparam logic [SW-1:0] HALF    = SW'(1) << (RANGE_BITS - 1);
  localparam logic [SW-1:0] QUARTER = SW'(1) << (RANGE_BITS - 2);
  localparam logic [SW-1:0] THREE_Q = SW'(3) << (RANGE_BITS - 2);

  logic [SW-1:0] range_low;
  logic [SW-1:0] range_high;
  logic [FW-1:0] pending_bits;
  logic [SW-1:0] interval;
  logic [CW-1:0] ch;
  logic [CW-1:0] cl;
  logic [CW-1:0] divisor;
  logic [PW-1:0] prod_hi;
  logic [PW-1:0] prod_lo;
  logic [SW-1:0] quot_hi;
  logic [SW-1:0] quot_lo;
  logic          div_busy;
  logic          out_bit;
  logic [FW-1:0] out_follow;

  logic [CW-1:0] tot_eff;
  logic [CW-1:0] cum_low;
  logic [CW-1:0] cum_high;
  logic [CW-1:0] ch_c;
  logic [CW-1:0] cl_c;
  logic [CW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic          low_side;
  logic [SW-1:0] low_m_half;
  logic [SW-1:0] high_m_half;
  logic [SW-1:0] low_m_q;
  logic [SW-1:0] high_m_q;
  logic [SW-1:0] em_low;
  logic [SW-1:0] em_high;
  logic [SW-1:0] sh_low;
  logic [SW-1:0] sh_high;
  logic          emit_cond;
  logic          next_emit;

  assign cum_low  = s_tdata[CW-1:0];
  assign cum_high = s_tdata[2*CW-1:CW];
  assign tot_eff  = (total_count == '0) ? CW'(1) : total_count;
  assign ch_c     = (cum_high > tot_eff) ? tot_eff : cum_high;
  assign cl_c     = (cum_low > ch_c) ? ch_c : cum_low;

  assign mul_b = cmd.mul_hi ? ch : cl;
  assign mul_p = interval * mul_b;

  assign low_side    = range_high < HALF;
  assign low_m_half  = range_low - HALF;
  assign high_m_half = range_high - HALF;
  assign low_m_q     = range_low - QUARTER;
  assign high_m_q    = range_high - QUARTER;
  assign em_low      = low_side ? {range_low[SW-2:0], 1'b0} : {low_m_half[SW-2:0], 1'b0};
  assign em_high     = low_side ? {range_high[SW-2:0], 1'b0} : {high_m_half[SW-2:0], 1'b0};
  assign sh_low      = {low_m_q[SW-2:0], 1'b0};
  assign sh_high     = {high_m_q[SW-2:0], 1'b0};
  assign emit_cond   = low_side || (range_low > HALF);
  assign next_emit   = (em_high < HALF) || (em_low > HALF);

  ace_div #(
    .QW (SW),
    .DW (CW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .dividend_a (prod_hi),
    .dividend_b (prod_lo),
    .divisor    (divisor),
    .busy       (div_busy),
    .quot_a     (quot_hi),
    .quot_b     (quot_lo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch       <= ch_c;
      cl       <= cl_c;
      divisor  <= tot_eff;
      interval <= range_high - range_low;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p;
    end
    if (cmd.mul_lo) begin
      prod_lo <= mul_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low    <= '0;
      range_high   <= WHOLE;
      pending_bits <= '0;
    end else if (cmd.update) begin
      range_high <= range_low + quot_hi;
      range_low  <= range_low + quot_lo;
    end else if (cmd.emit) begin
      range_low    <= em_low;
      range_high   <= em_high;
      pending_bits <= '0;
    end else if (cmd.shrink) begin
      range_low  <= sh_low;
      range_high <= sh_high;
      if (pending_bits < ace_pkg::PENDING_MAX) begin
        pending_bits <= pending_bits + FW'(1);
      end
    end else if (cmd.finish) begin
      range_low    <= '0;
      range_high   <= WHOLE;
      pending_bits <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bit    <= !low_side;
      out_follow <= pending_bits;
      m_tlast    <= !next_emit;
    end else if (cmd.finish) begin
      out_bit    <= (range_low > QUARTER);
      out_follow <= (pending_bits >= ace_pkg::PENDING_MAX) ? ace_pkg::PENDING_MAX
                                                           : pending_bits + FW'(1);
      m_tlast    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {(ace_pkg::OUT_DATA_W - FW - 1)'(0), out_follow, out_bit};

  assign status.in_finish   = s_tuser[0];
  assign status.in_empty    = (cl_c >= ch_c);
  assign status.div_busy    = div_busy;
  assign status.emit_cond   = emit_cond;
  assign status.shrink_cond = (range_low > QUARTER) && (range_high < THREE_Q);
  assign status.out_free    = !m_tvalid || m_tready;

  `ACE_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.emit || cmd.finish, !m_tvalid || m_tready)
  `ACE_ASSERT_NEXT(a_interval_open, clk, rst, cmd.update, range_high > range_low)
  `ACE_ASSERT_IMPL(a_pending_cap, clk, rst, 1'b1, pending_bits <= ace_pkg::PENDING_MAX)

endmodule

// ----- rtl/core/ace_ctrl.sv -----
// Controller state machine of the arithmetic coder encoder.
module ace_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ace_pkg::ace_status_t status,
  output ace_pkg::ace_cmd_t    cmd
);

  ace_pkg::ctrl_state_t state;
  ace_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ace_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ace_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.in_finish) begin
            state_next = ace_pkg::ST_FINISH;
          end else if (!status.in_empty) begin
            state_next = ace_pkg::ST_MUL_HI;
          end
        end
      end
      ace_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ace_pkg::ST_MUL_LO;
      end
      ace_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ace_pkg::ST_DIV_LOAD;
      end
      ace_pkg::ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ace_pkg::ST_DIV_WAIT;
      end
      ace_pkg::ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = ace_pkg::ST_UPDATE;
        end
      end
      ace_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ace_pkg::ST_RENORM;
      end
      ace_pkg::ST_RENORM: begin
        if (!status.emit_cond) begin
          state_next = ace_pkg::ST_SHRINK;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      ace_pkg::ST_SHRINK: begin
        if (status.shrink_cond) begin
          cmd.shrink = 1'b1;
        end else begin
          state_next = ace_pkg::ST_IDLE;
        end
      end
      ace_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ace_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ace_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/arithmetic_coder_encoder.sv -----
// Top level of the arithmetic coder encoder with its register port.
// An encode transaction scales the interval with the bit-serial divider, which produces
// one quotient bit per cycle for both scaled bounds at once, then emits runs and applies
// middle-quarter shrinks; a run waits while the output register is full. An empty symbol
// leaves the interval unchanged, and a finish transaction waits for a free output register.
// The next input transaction is taken once the current one is done, even while its last
// result still waits in the output register. total_count may be written only while the
// encoder is idle.
module arithmetic_coder_encoder #(
  parameter int RANGE_BITS = ace_pkg::RANGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ace_pkg::IN_DATA_W-1:0]   s_tdata,   // cum_low, cum_high
  input  logic [0:0]                      s_tuser,   // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ace_pkg::OUT_DATA_W-1:0]  m_tdata,   // bit_value, follow_count, zero pad
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ace_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ace_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ace_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [ace_pkg::CNT_W-1:0] total_count;
  logic                      reg_hit;
  ace_pkg::ace_cmd_t         cmd;
  ace_pkg::ace_status_t      status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ace_pkg::CFG_ADDR_W-1:2] == ace_pkg::REG_TOTAL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= ace_pkg::TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      total_count <= pwdata[ace_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? ace_pkg::CFG_DATA_W'(total_count) : '0;

  ace_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ace_datapath #(
    .RANGE_BITS (RANGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .total_count (total_count),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
